FILE: sv/sm3_pkg.sv
package sm3_pkg;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_COMPRESS,
      ST_FINISH,
      ST_OUTPUT
   } sm3_state_type;

   typedef logic [31:0] sm3_word_type;

   localparam sm3_word_type T_LOW  = 32'h79cc4519;
   localparam sm3_word_type T_HIGH = 32'h7a879d8a;
   // Round 16 uses the second constant rotated left by sixteen.
   localparam sm3_word_type T_HIGH_ROUND16 = {T_HIGH[15:0], T_HIGH[31:16]};

   localparam sm3_word_type IV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   localparam int unsigned ROUNDS = 64;
   localparam int unsigned BLOCK_WORDS = 16;

   function automatic sm3_word_type rotl(input sm3_word_type v, input int unsigned n);
      logic [4:0] sh;
      sh = n[4:0];
      if (sh == 5'd0) begin
         return v;
      end
      return (v << sh) | (v >> (6'd32 - {1'b0, sh}));
   endfunction

   function automatic sm3_word_type perm0(input sm3_word_type v);
      return v ^ rotl(v, 9) ^ rotl(v, 17);
   endfunction

   function automatic sm3_word_type perm1(input sm3_word_type v);
      return v ^ rotl(v, 15) ^ rotl(v, 23);
   endfunction

endpackage

FILE: sv/sm3_req_if.sv
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic        start_of_message;

   modport source (output valid, output message_word, output start_of_message, input ready);
   modport sink (input valid, input message_word, input start_of_message, output ready);
endinterface

FILE: sv/sm3_rsp_if.sv
interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

FILE: sv/sm3_block_compression_unit.sv
// After the sixteenth word of a block, the rounds run in ST_COMPRESS, the feed-forward in
// ST_FINISH, then the eight chaining words follow, one per cycle while the sink is ready.
// The request side is not ready again until the eighth digest word has been sent, and a
// single round unit runs one SM3 round per cycle with on-the-fly expansion.
// Reset clears the sequencer and word count and loads the chaining value with the SM3 IV.
module sm3_block_compression_unit (
   input logic       clock,
   input logic       reset,
   sm3_req_if.sink   req_ch,
   sm3_rsp_if.source rsp_ch
);

   sm3_pkg::sm3_state_type state_ff, state_in;

   logic [3:0]              word_count_ff, word_count_in;
   logic [5:0]              round_ff, round_in;
   logic [2:0]              out_idx_ff, out_idx_in;
   sm3_pkg::sm3_word_type   tj_ff, tj_in;
   sm3_pkg::sm3_word_type   w_ff [16];
   sm3_pkg::sm3_word_type   w_in [16];
   sm3_pkg::sm3_word_type   r_ff [8];
   sm3_pkg::sm3_word_type   r_in [8];
   sm3_pkg::sm3_word_type   cv_ff [8];
   sm3_pkg::sm3_word_type   cv_in [8];

   logic req_fire;
   logic rsp_fire;
   logic block_full;

   sm3_pkg::sm3_word_type a12, ss1, ss2, ffv, ggv, tt1, tt2, w_next;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign rsp_fire   = rsp_ch.valid && rsp_ch.ready;
   assign block_full = req_fire && !req_ch.start_of_message && (word_count_ff == 4'd15);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sm3_pkg::ST_COLLECT: begin
            if (block_full) begin
               state_in = sm3_pkg::ST_COMPRESS;
            end
         end
         sm3_pkg::ST_COMPRESS: begin
            if (round_ff == 6'(sm3_pkg::ROUNDS - 1)) begin
               state_in = sm3_pkg::ST_FINISH;
            end
         end
         sm3_pkg::ST_FINISH: begin
            state_in = sm3_pkg::ST_OUTPUT;
         end
         sm3_pkg::ST_OUTPUT: begin
            if (rsp_fire && (out_idx_ff == 3'd7)) begin
               state_in = sm3_pkg::ST_COLLECT;
            end
         end
         default: begin
            state_in = sm3_pkg::ST_COLLECT;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      case (state_ff)
         sm3_pkg::ST_COLLECT: begin
            req_ch.ready = 1'b1;
         end
         sm3_pkg::ST_OUTPUT: begin
            rsp_ch.valid = 1'b1;
         end
         default: begin
            req_ch.ready = 1'b0;
            rsp_ch.valid = 1'b0;
         end
      endcase
   end

   assign rsp_ch.digest_word = cv_ff[out_idx_ff];
   assign rsp_ch.word_index  = out_idx_ff;
   assign rsp_ch.last_word   = (out_idx_ff == 3'd7);

   // Round function and message expansion.
   always_comb begin
      a12 = sm3_pkg::rotl(r_ff[0], 12);
      ss1 = sm3_pkg::rotl(a12 + r_ff[4] + tj_ff, 7);
      ss2 = ss1 ^ a12;
      if (round_ff[5:4] == 2'b00) begin
         ffv = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         ggv = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ffv = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         ggv = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = ffv + r_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = ggv + r_ff[7] + ss1 + w_ff[0];
      w_next = sm3_pkg::perm1(w_ff[0] ^ w_ff[7] ^ sm3_pkg::rotl(w_ff[13], 15))
             ^ sm3_pkg::rotl(w_ff[3], 7) ^ w_ff[10];
   end

   // Datapath and counter next values.
   always_comb begin
      word_count_in = word_count_ff;
      round_in      = round_ff;
      out_idx_in    = out_idx_ff;
      tj_in         = tj_ff;
      w_in          = w_ff;
      r_in          = r_ff;
      cv_in         = cv_ff;
      case (state_ff)
         sm3_pkg::ST_COLLECT: begin
            if (req_fire) begin
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = w_ff[i + 1];
               end
               w_in[15] = req_ch.message_word;
               if (req_ch.start_of_message) begin
                  cv_in         = sm3_pkg::IV;
                  word_count_in = 4'd1;
               end else begin
                  word_count_in = word_count_ff + 4'd1;
               end
               r_in     = cv_ff;
               round_in = '0;
               tj_in    = sm3_pkg::T_LOW;
            end
         end
         sm3_pkg::ST_COMPRESS: begin
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = w_next;
            r_in[3]  = r_ff[2];
            r_in[2]  = sm3_pkg::rotl(r_ff[1], 9);
            r_in[1]  = r_ff[0];
            r_in[0]  = tt1;
            r_in[7]  = r_ff[6];
            r_in[6]  = sm3_pkg::rotl(r_ff[5], 19);
            r_in[5]  = r_ff[4];
            r_in[4]  = sm3_pkg::perm0(tt2);
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(sm3_pkg::BLOCK_WORDS - 1)) begin
               tj_in = sm3_pkg::T_HIGH_ROUND16;
            end else begin
               tj_in = sm3_pkg::rotl(tj_ff, 1);
            end
         end
         sm3_pkg::ST_FINISH: begin
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] ^ r_ff[i];
            end
            out_idx_in = '0;
         end
         sm3_pkg::ST_OUTPUT: begin
            if (rsp_fire) begin
               out_idx_in = out_idx_ff + 3'd1;
            end
         end
         default: begin
            out_idx_in = out_idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sm3_pkg::ST_COLLECT;
         word_count_ff <= '0;
         round_ff      <= '0;
         out_idx_ff    <= '0;
         cv_ff         <= sm3_pkg::IV;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         round_ff      <= round_in;
         out_idx_ff    <= out_idx_in;
         cv_ff         <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      tj_ff <= tj_in;
      w_ff  <= w_in;
      r_ff  <= r_in;
   end

endmodule

FILE: bench/tb_sm3_block_compression_unit.sv
`timescale 1ns / 1ps

module tb_sm3_block_compression_unit;

   localparam int RANDOM_WORDS = 306;
   localparam int DIRECTED_COUNT = 24;
   localparam int TOTAL_WORDS = DIRECTED_COUNT + RANDOM_WORDS;
   localparam int DRAIN_CYCLES = 200;

   localparam logic [31:0] ROUND_CONST_LOW  = 32'h79cc4519;
   localparam logic [31:0] ROUND_CONST_HIGH = 32'h7a879d8a;

   localparam logic [31:0] INIT_VECTOR [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   // Published digest of the three-byte message "abc", one padded block.
   localparam logic [31:0] ABC_DIGEST [8] = '{
      32'h66c7f0f4, 32'h62eeedd9, 32'hd1f2d46b, 32'hdc10e4e2,
      32'h4167c487, 32'h5cf2f7a2, 32'h297da02b, 32'h8f4ba8e0
   };

   typedef struct packed {
      logic [31:0] word;
      logic        start;
      logic        known_digest;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] digest;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   // The first block is the padded "abc" message sent without a start flag.
   // The rest hits the word extremes and start flags in the middle of a block.
   localparam stim_row_type DIRECTED [DIRECTED_COUNT] = '{
      '{32'h61626380, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0}, '{32'h00000018, 1'b0, 1'b1},
      '{32'hffffffff, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
      '{32'hffffffff, 1'b0, 1'b0}, '{32'hffffffff, 1'b1, 1'b0},
      '{32'h80000000, 1'b0, 1'b0}, '{32'h00000001, 1'b1, 1'b0},
      '{32'hffffffff, 1'b0, 1'b0}, '{32'h7fffffff, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sm3_req_if req_bus ();
   sm3_rsp_if rsp_bus ();

   sm3_block_compression_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #5 clock = ~clock;

   logic [31:0]      chain_value [8];
   logic [31:0]      block_buf [16];
   int               fill_count;
   digest_entry_type expected_digest_words [$];

   int send_idle_pct = 11;
   int recv_idle_pct = 76;
   int words_accepted = 0;
   int messages_started = 0;
   int digest_words_checked = 0;
   int mismatch_count = 0;

   function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
      logic [63:0] doubled;
      doubled = {v, v} << n[4:0];
      return doubled[63:32];
   endfunction

   function automatic logic [31:0] mix_p0(input logic [31:0] v);
      return v ^ rol32(v, 9) ^ rol32(v, 17);
   endfunction

   function automatic logic [31:0] mix_p1(input logic [31:0] v);
      return v ^ rol32(v, 15) ^ rol32(v, 23);
   endfunction

   function automatic void compress_held_block();
      logic [31:0] w [68];
      logic [31:0] r [8];
      logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
      for (int j = 0; j < 16; j++) w[j] = block_buf[j];
      for (int j = 16; j < 68; j++) begin
         w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
      end
      for (int k = 0; k < 8; k++) r[k] = chain_value[k];
      for (int j = 0; j < 64; j++) begin
         tj = (j < 16) ? ROUND_CONST_LOW : ROUND_CONST_HIGH;
         a12 = rol32(r[0], 12);
         ss1 = rol32(a12 + r[4] + rol32(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ffv = r[0] ^ r[1] ^ r[2];
            ggv = r[4] ^ r[5] ^ r[6];
         end else begin
            ffv = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
            ggv = (r[4] & r[5]) | (~r[4] & r[6]);
         end
         tt1 = ffv + r[3] + ss2 + (w[j] ^ w[j+4]);
         tt2 = ggv + r[7] + ss1 + w[j];
         r[3] = r[2];
         r[2] = rol32(r[1], 9);
         r[1] = r[0];
         r[0] = tt1;
         r[7] = r[6];
         r[6] = rol32(r[5], 19);
         r[5] = r[4];
         r[4] = mix_p0(tt2);
      end
      for (int k = 0; k < 8; k++) chain_value[k] = chain_value[k] ^ r[k];
   endfunction

   // Returns 1 when the word completes a block and the chaining value is updated.
   function automatic bit absorb_word(input logic [31:0] word, input logic start);
      if (start) begin
         for (int k = 0; k < 8; k++) chain_value[k] = INIT_VECTOR[k];
         fill_count = 0;
      end
      block_buf[fill_count] = word;
      fill_count++;
      if (fill_count < 16) return 1'b0;
      fill_count = 0;
      compress_held_block();
      return 1'b1;
   endfunction

   function automatic logic [31:0] random_word();
      int unsigned mode;
      mode = $urandom_range(0, 7);
      case (mode)
         0: return 32'h00000000;
         1: return 32'hffffffff;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic send_word(input logic [31:0] word, input logic start, input logic known);
      digest_entry_type entry;
      if (words_accepted < TOTAL_WORDS / 3) begin
         send_idle_pct = 11;
         recv_idle_pct = 76;
      end else if (words_accepted < 2 * TOTAL_WORDS / 3) begin
         send_idle_pct = 76;
         recv_idle_pct = 11;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.message_word <= $urandom;
         req_bus.start_of_message <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.message_word <= word;
      req_bus.start_of_message <= start;
      do @(posedge clock); while (!req_bus.ready);
      words_accepted++;
      if (start) messages_started++;
      if (absorb_word(word, start)) begin
         for (int k = 0; k < 8; k++) begin
            entry.digest = known ? ABC_DIGEST[k] : chain_value[k];
            entry.index = k[2:0];
            entry.last = (k == 7);
            expected_digest_words.push_back(entry);
         end
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      digest_entry_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_digest_words.size() == 0) begin
            report_mismatch($sformatf("unexpected digest word %08h index %0d",
                                      rsp_bus.digest_word, rsp_bus.word_index));
         end else begin
            want = expected_digest_words.pop_front();
            digest_words_checked++;
            if (rsp_bus.digest_word !== want.digest)
               report_mismatch($sformatf("digest_word %08h, expected %08h (index %0d)",
                                         rsp_bus.digest_word, want.digest, want.index));
            if (rsp_bus.word_index !== want.index)
               report_mismatch($sformatf("word_index %0d, expected %0d",
                                         rsp_bus.word_index, want.index));
            if (rsp_bus.last_word !== want.last)
               report_mismatch($sformatf("last_word %0b, expected %0b (index %0d)",
                                         rsp_bus.last_word, want.last, want.index));
         end
      end
   end

   initial begin
      #2000000;
      $display("sm3_block_compression_unit regression: fail");
      $finish;
   end

   initial begin
      int unsigned pick;
      int unsigned block_total;
      int unsigned frag_len;
      req_bus.valid = 1'b0;
      req_bus.message_word = 32'h0;
      req_bus.start_of_message = 1'b0;
      rsp_bus.ready = 1'b0;
      for (int k = 0; k < 8; k++) chain_value[k] = INIT_VECTOR[k];
      for (int k = 0; k < 16; k++) block_buf[k] = 32'h0;
      fill_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_word(DIRECTED[i].word, DIRECTED[i].start, DIRECTED[i].known_digest);
      end

      // Mostly whole messages of one to three blocks; the rest are fragments
      // that a later start flag throws away, with stray flags inside them.
      while (words_accepted < TOTAL_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            block_total = $urandom_range(1, 3);
            for (int b = 0; b < block_total; b++) begin
               for (int w = 0; w < 16; w++) begin
                  send_word(random_word(), (b == 0 && w == 0), 1'b0);
               end
            end
         end else begin
            frag_len = $urandom_range(1, 15);
            for (int w = 0; w < frag_len; w++) begin
               send_word(random_word(), (w == 0) || ($urandom_range(0, 3) == 0), 1'b0);
            end
         end
      end
      req_bus.valid <= 1'b0;

      while (expected_digest_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d message words (%0d directed) with %0d start flags.",
               words_accepted, DIRECTED_COUNT, messages_started);
      $display("Checked %0d digest words; %0d mismatches.",
               digest_words_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("sm3_block_compression_unit regression: pass");
      end else begin
         $display("sm3_block_compression_unit regression: fail");
      end
      $finish;
   end

endmodule
